// ----- rtl/slfp_pkg.sv -----
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared types and constants for the sync/length frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slfp_pkg;

	// byte and field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

	// configuration reset values
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd97;   // 'a'
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd102;  // 'f'
	localparam logic [BYTE_W-1:0] NO_ACTION       = 8'd78;   // 'N'

	// parse phases
	localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SYNC2   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ACTION  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

	// parser state carried between words
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [BYTE_W-1:0]  remaining;
		logic [BYTE_W-1:0]  received;
		logic [BYTE_W-1:0]  action;
	} state_t;

	// one result word
	typedef struct packed {
		logic              action_valid;
		logic [BYTE_W-1:0] action_code;
		logic              data_valid;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] data_index;
		logic [BYTE_W-1:0] data_count;
		logic              frame_done;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/slfp_step.sv -----
// ----------------------------------------------------------------------------
// slfp_step
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module slfp_step (
	input  wire slfp_pkg::state_t          cur,
	input  wire [slfp_pkg::BYTE_W-1:0]     in_byte,
	input  wire [slfp_pkg::BYTE_W-1:0]     sync_first,
	input  wire [slfp_pkg::BYTE_W-1:0]     sync_second,
	output slfp_pkg::state_t               nxt,
	output slfp_pkg::result_t              res
);

	logic has_left;
	logic last_byte;

	// payload bookkeeping
	assign has_left  = (cur.remaining != '0);
	assign last_byte = (cur.remaining <= 8'd1);

	// phase decode
	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.phase)
			slfp_pkg::PH_HUNT: begin
				if (in_byte == sync_first) nxt.phase = slfp_pkg::PH_SYNC2;
			end
			slfp_pkg::PH_SYNC2: begin
				// a wrong second sync is ignored, keep waiting
				if (in_byte == sync_second) nxt.phase = slfp_pkg::PH_ACTION;
			end
			slfp_pkg::PH_ACTION: begin
				nxt.action       = in_byte;
				res.action_valid = 1'b1;
				nxt.phase        = slfp_pkg::PH_LENGTH;
			end
			slfp_pkg::PH_LENGTH: begin
				nxt.remaining = in_byte;
				nxt.received  = '0;
				if (in_byte == '0) begin
					res.frame_done = 1'b1;
					nxt.phase      = slfp_pkg::PH_HUNT;
				end else begin
					nxt.phase = slfp_pkg::PH_PAYLOAD;
				end
			end
			slfp_pkg::PH_PAYLOAD: begin
				if (has_left) begin
					res.data_valid = 1'b1;
					res.data_byte  = in_byte;
					res.data_index = cur.received;
					nxt.received   = cur.received + 8'd1;
					nxt.remaining  = cur.remaining - 8'd1;
				end
				if (last_byte) begin
					res.frame_done = 1'b1;
					nxt.phase      = slfp_pkg::PH_HUNT;
				end
			end
			default: begin
				nxt.phase = slfp_pkg::PH_HUNT;
			end
		endcase
		res.action_code = nxt.action;
		res.data_count  = nxt.received;
	end

endmodule

`default_nettype wire

// ----- rtl/slfp_outbuf.sv -----
// ----------------------------------------------------------------------------
// slfp_outbuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module slfp_outbuf (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire slfp_pkg::result_t   push_data,
	output logic                     full,
	output logic                     out_valid,
	input  wire                      out_stall,
	output slfp_pkg::result_t        out_data
);

	logic              main_valid_q;
	logic              skid_valid_q;
	slfp_pkg::result_t main_q;
	slfp_pkg::result_t skid_q;
	logic              pop;

	assign pop       = main_valid_q & ~out_stall;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign full      = skid_valid_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (push) begin
			main_valid_q <= 1'b1;
			if (main_valid_q && !pop) skid_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) main_q <= skid_q;
		end else if (push) begin
			if (!main_valid_q || pop) main_q <= push_data;
			else skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sync_length_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// sync_length_frame_parser_core
// Deframer for sync, sync, action, length, payload byte streams.
// ----------------------------------------------------------------------------
// Input channel: one received byte per word on in_byte, in_valid/in_stall.
// Output channel: one result word per input word, out_valid/out_stall,
// reporting action capture, payload byte with index, running payload count
// and frame completion.
// Config: cfg_we writes cfg_data into sync_first (index 0) or sync_second
// (index 1); write only while no word is in flight.
// Output: the result of an accepted byte is registered in the output buffer before it is shown.
// Throughput: one byte per cycle while in_stall is low; the parser state update is a single
// compare/increment step between the state registers.
// Reset: phase returns to hunting, counts clear, action code reads 'N',
// sync bytes return to 'a' and 'f'; no words are held.
// Stall: results queue in a two-entry buffer; in_stall rises only when both
// entries are full, so one more byte is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_frame_parser_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [slfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [slfp_pkg::BYTE_W-1:0]         cfg_data,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire [slfp_pkg::BYTE_W-1:0]         in_byte,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic                               action_valid,
	output logic [slfp_pkg::BYTE_W-1:0]        action_code,
	output logic                               data_valid,
	output logic [slfp_pkg::BYTE_W-1:0]        data_byte,
	output logic [slfp_pkg::BYTE_W-1:0]        data_index,
	output logic [slfp_pkg::BYTE_W-1:0]        data_count,
	output logic                               frame_done
);

	logic [slfp_pkg::BYTE_W-1:0] sync_first_q;
	logic [slfp_pkg::BYTE_W-1:0] sync_second_q;
	slfp_pkg::state_t            state_q;
	slfp_pkg::state_t            state_nxt;
	slfp_pkg::result_t           res_nxt;
	slfp_pkg::result_t           res_out;
	logic                        accept;
	logic                        buf_full;

	assign in_stall = buf_full;
	assign accept   = in_valid & ~buf_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= slfp_pkg::SYNC_FIRST_RST;
			sync_second_q <= slfp_pkg::SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slfp_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				slfp_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= slfp_pkg::PH_HUNT;
			state_q.remaining <= '0;
			state_q.received  <= '0;
			state_q.action    <= slfp_pkg::NO_ACTION;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	slfp_step u_step (
		.cur         (state_q),
		.in_byte     (in_byte),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	slfp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_nxt),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	// result fields
	assign action_valid = res_out.action_valid;
	assign action_code  = res_out.action_code;
	assign data_valid   = res_out.data_valid;
	assign data_byte    = res_out.data_byte;
	assign data_index   = res_out.data_index;
	assign data_count   = res_out.data_count;
	assign frame_done   = res_out.frame_done;

endmodule

`default_nettype wire

// ----- rtl/slfp_checker.sv -----
// ----------------------------------------------------------------------------
// slfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slfp_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_stall,
	input wire                          out_valid,
	input wire                          out_stall,
	input wire                          action_valid,
	input wire [slfp_pkg::BYTE_W-1:0]   action_code,
	input wire                          data_valid,
	input wire [slfp_pkg::BYTE_W-1:0]   data_byte,
	input wire [slfp_pkg::BYTE_W-1:0]   data_index,
	input wire [slfp_pkg::BYTE_W-1:0]   data_count,
	input wire                          frame_done
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action_code)
			&& $stable(data_byte) && $stable(data_count) && $stable(frame_done))
		else $error("stalled result changed");

	// a byte is never both action code and payload
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(action_valid && data_valid))
		else $error("action and data flagged together");

	// payload count runs one ahead of the index
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_valid |-> data_count == data_index + 8'd1)
		else $error("payload count out of step with index");

	// non-payload words carry zero data fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> data_byte == '0 && data_index == '0)
		else $error("data fields set without payload");

	// input stalls only with a result pending
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind sync_length_frame_parser_core slfp_checker u_slfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.action_valid (action_valid),
	.action_code  (action_code),
	.data_valid   (data_valid),
	.data_byte    (data_byte),
	.data_index   (data_index),
	.data_count   (data_count),
	.frame_done   (frame_done)
);

`default_nettype wire
